// ===== hw/rtl/aesp_pkg.sv =====
// ----------------------------------------------------------------------------
// Active/expired priority scheduler package
// Shared defaults, status codes and the result record of the scheduler.
// ----------------------------------------------------------------------------
package aesp_pkg;

  // Default sizing of the scheduler
  localparam int unsigned DefMaxLevels = 8;
  localparam int unsigned DefLevelDepth = 16;
  localparam int unsigned DefIdWidth = 8;

  // Field widths fixed by the stream format
  localparam int unsigned CfgWidth = 4;
  localparam int unsigned PidWidth = 8;
  localparam int unsigned PrioWidth = 4;
  localparam int unsigned OutLvlWidth = 3;
  localparam int unsigned NlWidth = 5;
  localparam int unsigned InDataWidth = 16;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [CfgWidth-1:0] NumLevelsReset = 4'd4;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TAKE = 1'b1
  } action_e;

  // One result record; status sits in the lowest bits
  typedef struct packed {
    logic                   banks_swapped;
    logic                   to_expired;
    logic [OutLvlWidth-1:0] level;
    logic [PidWidth-1:0]    chosen_id;
    status_e                status;
  } res_t;

endpackage

// ===== hw/rtl/aesp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module aesp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/active_expired_priority_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Active/expired priority scheduler
// Sequence: an add fetches its descriptor and finishes in ST_DESC; a take fetches its
//   descriptor, pops in ST_DESC and finishes in ST_READ with the queue memory data.
// Flow: the input is taken only in ST_IDLE with no result held, so a new add or take
//   waits until the last one is through; both memories are synchronous RAMs with
//   registered reads. An out-of-range add or an empty take finishes in ST_IDLE.
// Reset: bank select clears; pointers and counts clear at once through per-FIFO
//   valid bits; the queue memory needs no clearing pass and holds undefined data.
// ----------------------------------------------------------------------------
module active_expired_priority_scheduler_unit #(
  parameter int unsigned MAX_LEVELS  = aesp_pkg::DefMaxLevels,
  parameter int unsigned LEVEL_DEPTH = aesp_pkg::DefLevelDepth,
  parameter int unsigned ID_WIDTH    = aesp_pkg::DefIdWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: num_levels
  input  logic                                 cfg_we_i,
  input  logic [aesp_pkg::CfgWidth-1:0]        cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // process_id[7:0], dynamic_priority[11:8], static_priority[15:12]
  input  logic [aesp_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  // action[0]
  input  logic                                 s_axis_tuser_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // status[1:0], chosen_id[9:2], level[12:10], to_expired[13],
  // banks_swapped[14], zero[15]
  output logic [aesp_pkg::OutDataWidth-1:0]    m_axis_tdata_o
);

  localparam int unsigned NumFifos = 2 * MAX_LEVELS;
  localparam int unsigned FifoW    = $clog2(NumFifos);
  localparam int unsigned LvlW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned PtrW     = $clog2(LEVEL_DEPTH);
  localparam int unsigned CntW     = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned QDepth   = NumFifos * LEVEL_DEPTH;
  localparam int unsigned QaW      = $clog2(QDepth);
  localparam int unsigned DescW    = 2 * PtrW + CntW;
  localparam int unsigned NlW      = aesp_pkg::NlWidth;

  // Per-FIFO descriptor kept in the descriptor memory
  typedef struct packed {
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
    logic [CntW-1:0] cnt;
  } desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_READ
  } state_e;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                       state_q, state_d;
  logic [aesp_pkg::CfgWidth-1:0] nlev_q, nlev_d;
  logic                         act_bank_q, act_bank_d;
  logic [NumFifos-1:0]          desc_vld_q, desc_vld_d;   // descriptor ever written
  logic [NumFifos-1:0]          ne_q, ne_d;               // FIFO holds at least one id
  aesp_pkg::action_e            op_q, op_d;
  logic [FifoW-1:0]             f_q, f_d;
  logic [aesp_pkg::PidWidth-1:0] id_q, id_d;
  logic [aesp_pkg::OutLvlWidth-1:0] lvl_q, lvl_d;
  logic                         exp_q, exp_d;
  logic                         swp_q, swp_d;
  logic                         pend_q, pend_d;
  aesp_pkg::res_t               pend_res_q, pend_res_d;
  logic                         m_valid_q, m_valid_d;
  aesp_pkg::res_t               out_q, out_d;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic              desc_we;
  logic [FifoW-1:0]  desc_raddr;
  logic [DescW-1:0]  desc_wdata, desc_rdata;
  logic              q_we;
  logic [QaW-1:0]    q_waddr, q_raddr;
  logic [ID_WIDTH-1:0] q_wdata, q_rdata;

  aesp_ram #(
    .WIDTH (DescW),
    .DEPTH (NumFifos)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (f_q),
    .wdata_i (desc_wdata),
    .raddr_i (desc_raddr),
    .rdata_o (desc_rdata)
  );

  aesp_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (QDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [aesp_pkg::PidWidth-1:0]  in_pid;
  logic [aesp_pkg::PrioWidth-1:0] in_dyn;
  logic [aesp_pkg::PrioWidth-1:0] in_stat;
  logic                           in_accept;
  logic                           out_free;

  assign in_pid  = s_axis_tdata_i[7:0];
  assign in_dyn  = s_axis_tdata_i[11:8];
  assign in_stat = s_axis_tdata_i[15:12];

  assign s_axis_tready_o = (state_q == ST_IDLE) && !pend_q;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Levels in use: zero acts as one, clamp to the number built
  logic [NlW-1:0] nl;
  always_comb begin
    if (nlev_q == '0) begin
      nl = NlW'(1);
    end else if (NlW'(nlev_q) > NlW'(MAX_LEVELS)) begin
      nl = NlW'(MAX_LEVELS);
    end else begin
      nl = NlW'(nlev_q);
    end
  end

  // Add: refill a negative dynamic priority and target the expired bank
  logic           add_neg;
  logic           tgt_neg;
  logic [NlW-1:0] tgt;
  logic           add_oor;
  logic           add_bank;
  logic [FifoW-1:0] f_add;

  assign add_neg  = in_dyn[aesp_pkg::PrioWidth-1];
  assign tgt_neg  = add_neg && (in_stat == '0);
  assign tgt      = add_neg ? (NlW'(in_stat) - NlW'(1))
                            : NlW'(in_dyn[aesp_pkg::PrioWidth-2:0]);
  assign add_oor  = tgt_neg || (tgt >= nl);
  assign add_bank = act_bank_q ^ add_neg;
  assign f_add    = FifoW'(int'(add_bank) * MAX_LEVELS + int'(tgt));

  // Take: per-bank occupancy over levels in use, then pick the highest level
  logic [MAX_LEVELS-1:0] act_vec, exp_vec, pick_vec;
  logic                  act_empty, exp_empty;
  logic [LvlW-1:0]       hi;
  logic                  take_bank;
  logic [FifoW-1:0]      f_take;

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      act_vec[i] = ne_q[FifoW'(int'(act_bank_q) * MAX_LEVELS + i)] && (i < int'(nl));
      exp_vec[i] = ne_q[FifoW'(int'(!act_bank_q) * MAX_LEVELS + i)] && (i < int'(nl));
    end
  end

  assign act_empty = ~|act_vec;
  assign exp_empty = ~|exp_vec;
  assign pick_vec  = act_empty ? exp_vec : act_vec;
  assign take_bank = act_bank_q ^ act_empty;

  always_comb begin
    hi = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (pick_vec[i]) begin
        hi = LvlW'(i);
      end
    end
  end

  assign f_take = FifoW'(int'(take_bank) * MAX_LEVELS + int'(hi));

  // Fetch the descriptor of the FIFO this transaction will touch
  assign desc_raddr = s_axis_tuser_i ? f_take : f_add;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  desc_t          desc_cur, desc_new;
  logic           fin;
  aesp_pkg::res_t fin_res;

  assign desc_cur   = desc_vld_q[f_q] ? desc_t'(desc_rdata) : '0;
  assign desc_wdata = DescW'(desc_new);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    state_d    = state_q;
    nlev_d     = nlev_q;
    act_bank_d = act_bank_q;
    desc_vld_d = desc_vld_q;
    ne_d       = ne_q;
    op_d       = op_q;
    f_d        = f_q;
    id_d       = id_q;
    lvl_d      = lvl_q;
    exp_d      = exp_q;
    swp_d      = swp_q;
    pend_d     = pend_q;
    pend_res_d = pend_res_q;
    m_valid_d  = m_valid_q;
    out_d      = out_q;

    desc_we  = 1'b0;
    desc_new = desc_cur;
    q_we     = 1'b0;
    q_waddr  = QaW'(int'(f_q) * LEVEL_DEPTH + int'(desc_cur.tail));
    q_raddr  = QaW'(int'(f_q) * LEVEL_DEPTH + int'(desc_cur.head));
    q_wdata  = ID_WIDTH'(id_q);
    fin      = 1'b0;
    fin_res  = '0;

    if (cfg_we_i) begin
      nlev_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser_i == aesp_pkg::ACT_TAKE) begin
            if (act_empty && exp_empty) begin
              fin            = 1'b1;
              fin_res.status = aesp_pkg::STATUS_EMPTY;
            end else begin
              // swap first when only the active bank is empty
              act_bank_d = take_bank;
              op_d       = aesp_pkg::ACT_TAKE;
              f_d        = f_take;
              lvl_d      = aesp_pkg::OutLvlWidth'(hi);
              swp_d      = act_empty;
              state_d    = ST_DESC;
            end
          end else begin
            id_d  = in_pid;
            exp_d = add_neg;
            if (add_oor) begin
              fin                = 1'b1;
              fin_res.status     = aesp_pkg::STATUS_RANGE;
              fin_res.chosen_id  = in_pid;
              fin_res.to_expired = add_neg;
            end else begin
              op_d    = aesp_pkg::ACT_ADD;
              f_d     = f_add;
              lvl_d   = aesp_pkg::OutLvlWidth'(tgt);
              state_d = ST_DESC;
            end
          end
        end
      end

      ST_DESC: begin
        state_d = ST_IDLE;
        if (op_q == aesp_pkg::ACT_ADD) begin
          fin                = 1'b1;
          fin_res.chosen_id  = id_q;
          fin_res.level      = lvl_q;
          fin_res.to_expired = exp_q;
          if (desc_cur.cnt == CntW'(LEVEL_DEPTH)) begin
            fin_res.status = aesp_pkg::STATUS_FULL;
          end else begin
            // push at the tail, bump the tail and the count
            fin_res.status  = aesp_pkg::STATUS_OK;
            q_we            = 1'b1;
            desc_we         = 1'b1;
            desc_new.tail   = ptr_inc(desc_cur.tail);
            desc_new.cnt    = desc_cur.cnt + CntW'(1);
            desc_vld_d[f_q] = 1'b1;
            ne_d[f_q]       = 1'b1;
          end
        end else begin
          // pop from the head; id arrives next cycle
          desc_we         = 1'b1;
          desc_new.head   = ptr_inc(desc_cur.head);
          desc_new.cnt    = desc_cur.cnt - CntW'(1);
          desc_vld_d[f_q] = 1'b1;
          ne_d[f_q]       = (desc_cur.cnt != CntW'(1));
          state_d         = ST_READ;
        end
      end

      ST_READ: begin
        fin                   = 1'b1;
        fin_res.status        = aesp_pkg::STATUS_OK;
        fin_res.chosen_id     = aesp_pkg::PidWidth'(q_rdata);
        fin_res.level         = lvl_q;
        fin_res.banks_swapped = swp_q;
        state_d               = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register with a one-deep hold for a result that finds it busy
    if (fin) begin
      if (out_free) begin
        out_d     = fin_res;
        m_valid_d = 1'b1;
      end else begin
        pend_res_d = fin_res;
        pend_d     = 1'b1;
      end
    end else if (pend_q && out_free) begin
      out_d     = pend_res_q;
      m_valid_d = 1'b1;
      pend_d    = 1'b0;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      nlev_q     <= aesp_pkg::NumLevelsReset;
      act_bank_q <= 1'b0;
      desc_vld_q <= '0;
      ne_q       <= '0;
      op_q       <= aesp_pkg::ACT_ADD;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      nlev_q     <= nlev_d;
      act_bank_q <= act_bank_d;
      desc_vld_q <= desc_vld_d;
      ne_q       <= ne_d;
      op_q       <= op_d;
      pend_q     <= pend_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    id_q       <= id_d;
    lvl_q      <= lvl_d;
    exp_q      <= exp_d;
    swp_q      <= swp_d;
    pend_res_q <= pend_res_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = aesp_pkg::OutDataWidth'(out_q);

endmodule
